@@ hw/rtl/mbww_pkg.sv @@
// Package for the mono bitmap window writer: request codes, panel command
// bytes and the queue entry passed from the front end to the back end.
// No dependencies.
package mbww_pkg;

   localparam logic OP_WINDOW = 1'b0;
   localparam logic OP_BITMAP = 1'b1;

   localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
   localparam logic [7:0] CMD_ROW_SET    = 8'h2B;
   localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;
   localparam logic [7:0] ADDR_HIGH      = 8'h00;

   localparam logic [2:0] CSR_FORE_COLOR    = 3'd0;
   localparam logic [2:0] CSR_BACK_COLOR    = 3'd1;
   localparam logic [2:0] CSR_COLUMN_ORIGIN = 3'd2;
   localparam logic [2:0] CSR_ROW_ORIGIN    = 3'd3;

   localparam logic [3:0] STEP_COL_CMD   = 4'd0;
   localparam logic [3:0] STEP_COL_SH    = 4'd1;
   localparam logic [3:0] STEP_COL_SL    = 4'd2;
   localparam logic [3:0] STEP_COL_EH    = 4'd3;
   localparam logic [3:0] STEP_COL_EL    = 4'd4;
   localparam logic [3:0] STEP_ROW_CMD   = 4'd5;
   localparam logic [3:0] STEP_ROW_SH    = 4'd6;
   localparam logic [3:0] STEP_ROW_SL    = 4'd7;
   localparam logic [3:0] STEP_ROW_EH    = 4'd8;
   localparam logic [3:0] STEP_ROW_EL    = 4'd9;
   localparam logic [3:0] STEP_WRITE_CMD = 4'd10;

   typedef enum logic {
      KIND_WINDOW,
      KIND_PIXELS
   } kind_type;

   // For pixel entries, col_start carries the bitmap byte.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] col_start;
      logic [7:0] col_end;
      logic [7:0] row_start;
      logic [7:0] row_end;
      logic [3:0] count;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

endpackage

@@ hw/rtl/mono_bitmap_window_writer_unit.sv @@
// Mono bitmap window writer: one-bit bitmap to RGB565 bytes on an 8-bit bus.
// A request's first bus byte passes through the queue, then the output register.
// Output: one bus byte per cycle from the back-end output register while
// rsp_stall is low; a window request gives 11 bytes, a bitmap request up to 16.
// Reset clears the window state, the queue and the output valid flag, and sets
// colors to white on black with zero origins. Depends on all mbww_* files.
module mono_bitmap_window_writer_unit
   import mbww_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_win_x,
   input  logic [7:0]  req_win_y,
   input  logic [7:0]  req_win_width,
   input  logic [7:0]  req_win_height,
   input  logic [7:0]  req_bitmap_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_bus_byte,
   output logic        rsp_is_data,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] fore_color_ff;
   logic [15:0] back_color_ff;
   logic [7:0]  column_origin_ff;
   logic [7:0]  row_origin_ff;

   push_type  push;
   logic      queue_full;
   logic      queue_empty;
   logic      pop;
   entry_type head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fore_color_ff    <= 16'hFFFF;
         back_color_ff    <= 16'h0000;
         column_origin_ff <= 8'd0;
         row_origin_ff    <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FORE_COLOR:    fore_color_ff    <= csr_data;
            CSR_BACK_COLOR:    back_color_ff    <= csr_data;
            CSR_COLUMN_ORIGIN: column_origin_ff <= csr_data[7:0];
            CSR_ROW_ORIGIN:    row_origin_ff    <= csr_data[7:0];
            default:           ;
         endcase
      end
   end

   mbww_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_win_x       (req_win_x),
      .req_win_y       (req_win_y),
      .req_win_width   (req_win_width),
      .req_win_height  (req_win_height),
      .req_bitmap_byte (req_bitmap_byte),
      .column_origin   (column_origin_ff),
      .row_origin      (row_origin_ff),
      .queue_full      (queue_full),
      .push            (push)
   );

   mbww_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .empty (queue_empty),
      .head  (head)
   );

   mbww_back u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (queue_empty),
      .head         (head),
      .pop          (pop),
      .fore_color   (fore_color_ff),
      .back_color   (back_color_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_bus_byte (rsp_bus_byte),
      .rsp_is_data  (rsp_is_data),
      .rsp_last     (rsp_last)
   );

endmodule

@@ hw/rtl/mbww_front.sv @@
// Front end: accepts requests, tracks window position, turns each window request
// and each bitmap request with pixels left into a queue entry. Depends on mbww_pkg.
module mbww_front
   import mbww_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_win_x,
   input  logic [7:0] req_win_y,
   input  logic [7:0] req_win_width,
   input  logic [7:0] req_win_height,
   input  logic [7:0] req_bitmap_byte,
   input  logic [7:0] column_origin,
   input  logic [7:0] row_origin,
   input  logic       queue_full,
   output push_type   push
);

   logic [7:0] width_ff, width_in;
   logic [7:0] height_ff, height_in;
   logic [7:0] column_count_ff, column_count_in;
   logic [7:0] row_count_ff, row_count_in;

   logic       accept;
   logic       active;
   logic [7:0] remaining;
   logic       row_end;
   logic [3:0] count;
   logic [7:0] col_start;
   logic [7:0] row_start;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign active    = row_count_ff < height_ff;
   assign remaining = (column_count_ff < width_ff) ? (width_ff - column_count_ff) : 8'd0;
   assign row_end   = remaining <= 8'd8;
   assign count     = row_end ? remaining[3:0] : 4'd8;
   assign col_start = column_origin + req_win_x;
   assign row_start = row_origin + req_win_y;

   always_comb begin
      width_in        = width_ff;
      height_in       = height_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      push.push       = 1'b0;
      push.entry      = '0;
      if (req_op == OP_WINDOW) begin
         push.entry.kind      = KIND_WINDOW;
         push.entry.col_start = col_start;
         push.entry.col_end   = col_start + req_win_width - 8'd1;
         push.entry.row_start = row_start;
         push.entry.row_end   = row_start + req_win_height - 8'd1;
         push.entry.count     = 4'd0;
         if (accept) begin
            push.push       = 1'b1;
            width_in        = req_win_width;
            height_in       = req_win_height;
            column_count_in = 8'd0;
            row_count_in    = 8'd0;
         end
      end else begin
         push.entry.kind      = KIND_PIXELS;
         push.entry.col_start = req_bitmap_byte;
         push.entry.count     = count;
         if (accept && active) begin
            push.push = count != 4'd0;
            if (row_end) begin
               column_count_in = 8'd0;
               row_count_in    = row_count_ff + 8'd1;
            end else begin
               column_count_in = column_count_ff + 8'd8;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff        <= 8'd0;
         height_ff       <= 8'd0;
         column_count_ff <= 8'd0;
         row_count_ff    <= 8'd0;
      end else begin
         width_ff        <= width_in;
         height_ff       <= height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

endmodule

@@ hw/rtl/mbww_queue.sv @@
// Short register queue between the front end and the back end.
// Depends on mbww_pkg.
module mbww_queue
   import mbww_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output entry_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type     store_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full    = count_ff == CW'(DEPTH);
   assign empty   = count_ff == '0;
   assign head    = store_ff[rd_ptr_ff];
   assign do_push = push.push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/mbww_back.sv @@
// Back end: expands the queue head into bus bytes, one per cycle while the
// output is not stalled, into the response output register. Depends on mbww_pkg.
module mbww_back
   import mbww_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       empty,
   input  entry_type  head,
   output logic       pop,
   input  logic [15:0] fore_color,
   input  logic [15:0] back_color,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_bus_byte,
   output logic       rsp_is_data,
   output logic       rsp_last
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_bus_byte_ff;
   logic       rsp_is_data_ff;
   logic       rsp_last_ff;
   logic [3:0] step_ff, step_in;

   logic        out_free;
   logic        emit;
   logic [7:0]  byte_val;
   logic        data_val;
   logic        last_val;
   logic [2:0]  pixel;
   logic        bit_set;
   logic [15:0] color;
   logic [4:0]  last_step;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = !empty && out_free;
   assign pixel     = step_ff[3:1];
   assign bit_set   = head.col_start[~pixel];
   assign color     = bit_set ? fore_color : back_color;
   assign last_step = {head.count, 1'b0} - 5'd1;

   always_comb begin
      byte_val = ADDR_HIGH;
      data_val = 1'b1;
      last_val = 1'b0;
      if (head.kind == KIND_WINDOW) begin
         unique case (step_ff)
            STEP_COL_CMD: begin
               byte_val = CMD_COLUMN_SET;
               data_val = 1'b0;
            end
            STEP_COL_SL:  byte_val = head.col_start;
            STEP_COL_EL:  byte_val = head.col_end;
            STEP_ROW_CMD: begin
               byte_val = CMD_ROW_SET;
               data_val = 1'b0;
            end
            STEP_ROW_SL:  byte_val = head.row_start;
            STEP_ROW_EL:  byte_val = head.row_end;
            STEP_WRITE_CMD: begin
               byte_val = CMD_MEM_WRITE;
               data_val = 1'b0;
               last_val = 1'b1;
            end
            default:      byte_val = ADDR_HIGH;
         endcase
      end else begin
         byte_val = step_ff[0] ? color[7:0] : color[15:8];
         last_val = {1'b0, step_ff} == last_step;
      end
   end

   assign pop = emit && last_val;

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         step_in = last_val ? 4'd0 : step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= 4'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
      if (emit) begin
         rsp_bus_byte_ff <= byte_val;
         rsp_is_data_ff  <= data_val;
         rsp_last_ff     <= last_val;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_bus_byte = rsp_bus_byte_ff;
   assign rsp_is_data  = rsp_is_data_ff;
   assign rsp_last     = rsp_last_ff;

endmodule
